// ----- design/conv3g_pkg.sv -----
package conv3g_pkg;

   localparam int PIXEL_W  = 8;
   localparam int WEIGHT_W = 7;
   localparam int TAPS     = 9;
   localparam int TAP_W    = 4;
   localparam int ACC_W    = 19;
   localparam int FACTOR_W = 11;
   localparam int MAG_W    = 18;
   localparam int DVS_W    = 10;
   localparam int STEP_W   = 5;
   localparam int PROD_W   = 16;
   localparam int CNT_W    = 13;
   localparam int ROW_W    = 12;

   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;
   localparam int WEIGHTS_REG_W = 63;
   localparam int CSR_DATA_W    = 63;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_WEIGHTS = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]   WIDTH_RESET   = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0]  HEIGHT_RESET  = 13'd1024;
   localparam logic [WEIGHTS_REG_W-1:0] WEIGHTS_RESET = 63'd72624976668147841;

   localparam logic [CNT_W-1:0] MIN_DIM      = 13'd3;
   localparam logic [CNT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   localparam int HALF_OFFSET = 128;
   localparam int PIXEL_MAX   = 255;

   typedef struct packed {
      logic                       start;
      logic signed [ACC_W-1:0]    dividend;
      logic signed [FACTOR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_res_type;

endpackage

// ----- design/conv3g_if.sv -----
interface conv3g_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface conv3g_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] filtered;
   logic       frame_end;

   modport source (output valid, output filtered, output frame_end, input ready);
   modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

// ----- design/conv3g_ram.sv -----
module conv3g_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/conv3g_divider.sv -----
module conv3g_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  conv3g_pkg::div_cmd_type   cmd,
   output conv3g_pkg::div_res_type   res
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               neg_ff, neg_in;
   logic [conv3g_pkg::STEP_W-1:0]      count_ff, count_in;
   logic [conv3g_pkg::MAG_W-1:0]       dividend_ff, dividend_in;
   logic [conv3g_pkg::DVS_W-1:0]       divisor_ff, divisor_in;
   logic [conv3g_pkg::DVS_W-1:0]       rem_ff, rem_in;
   logic [conv3g_pkg::MAG_W-1:0]       quo_ff, quo_in;

   logic signed [conv3g_pkg::ACC_W-1:0]    dividend_abs;
   logic signed [conv3g_pkg::FACTOR_W-1:0] divisor_abs;
   logic [conv3g_pkg::DVS_W:0]             rem_shift;
   logic [conv3g_pkg::DVS_W+1:0]           trial;
   logic                                   fits;
   logic signed [conv3g_pkg::ACC_W-1:0]    quo_signed;

   assign dividend_abs = cmd.dividend[conv3g_pkg::ACC_W-1] ? -cmd.dividend : cmd.dividend;
   assign divisor_abs  = cmd.divisor[conv3g_pkg::FACTOR_W-1] ? -cmd.divisor : cmd.divisor;

   // Restoring division, one quotient bit per cycle, most significant first.
   assign rem_shift = {rem_ff, dividend_ff[conv3g_pkg::MAG_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign fits      = ~trial[conv3g_pkg::DVS_W+1];

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      neg_in      = neg_ff;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      if (cmd.start) begin
         busy_in     = 1'b1;
         neg_in      = cmd.dividend[conv3g_pkg::ACC_W-1] ^ cmd.divisor[conv3g_pkg::FACTOR_W-1];
         count_in    = conv3g_pkg::STEP_W'(conv3g_pkg::MAG_W - 1);
         dividend_in = dividend_abs[conv3g_pkg::MAG_W-1:0];
         divisor_in  = divisor_abs[conv3g_pkg::DVS_W-1:0];
         rem_in      = '0;
         quo_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[conv3g_pkg::MAG_W-2:0], 1'b0};
         rem_in      = fits ? trial[conv3g_pkg::DVS_W-1:0] : rem_shift[conv3g_pkg::DVS_W-1:0];
         quo_in      = {quo_ff[conv3g_pkg::MAG_W-2:0], fits};
         count_in    = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff      <= neg_in;
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
   end

   assign quo_signed   = $signed({1'b0, quo_ff});
   assign res.done     = done_ff;
   assign res.quotient = neg_ff ? -quo_signed : quo_signed;

endmodule

// ----- design/conv3x3_gray_normalized.sv -----
// 3x3 convolution over a raster stream of 8-bit grayscale pixels. Two previous rows
// live in one synchronous line store of MAX_WIDTH words (each word holds the pixel two
// rows up and one row up at that column), so any row width up to MAX_WIDTH works.
// Every pixel is accepted in ST_IDLE, which reads the line store, and ST_READ, which
// writes it back and shifts the 3x3 window. A pixel that completes an interior window
// then runs a multiply-accumulate over the nine taps through a single multiplier, a
// normalize step, and, when the nine weights do not sum to zero, a bit-serial divider;
// the result is then clamped to 0..255. Results go to an output register, so the next
// pixel is taken while a result waits. A frame starts on frame_start or after the last
// pixel of the previous frame, and frame_end marks the result of the last interior
// position. Width and height saturate to 3..MAX_WIDTH and 3..4096; the kernel register
// packs nine signed 7-bit weights, row-major, weight k in bits 7k+6..7k.
module conv3x3_gray_normalized #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   conv3g_req_if.sink                          req_ch,
   conv3g_rsp_if.source                        rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [conv3g_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [conv3g_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam logic [conv3g_pkg::CNT_W-1:0] MAX_W_EXT = conv3g_pkg::CNT_W'(MAX_WIDTH);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MAC  = 6'b000100,
      ST_NORM = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [conv3g_pkg::WIDTH_REG_W-1:0]   width_ff;
   logic [conv3g_pkg::HEIGHT_REG_W-1:0]  height_ff;
   logic [conv3g_pkg::WEIGHTS_REG_W-1:0] weights_ff;

   logic [COL_W-1:0]             col_ff, col_in;
   logic [conv3g_pkg::ROW_W-1:0] row_ff, row_in;

   logic [COL_W-1:0]                    addr_ff;
   logic [conv3g_pkg::PIXEL_W-1:0]      px_ff;
   logic                                produce_ff, produce_in;
   logic                                last_ff, last_in;
   logic [conv3g_pkg::PIXEL_W-1:0]      window_ff [conv3g_pkg::TAPS];
   logic [conv3g_pkg::TAP_W-1:0]        tap_ff, tap_in;
   logic signed [conv3g_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [conv3g_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   logic signed [conv3g_pkg::ACC_W-1:0]    value_ff, value_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [conv3g_pkg::PIXEL_W-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                           rsp_frame_end_ff, rsp_frame_end_in;

   logic                           accept;
   logic [COL_W-1:0]               c_sel;
   logic [conv3g_pkg::ROW_W-1:0]   r_sel;
   logic [conv3g_pkg::CNT_W-1:0]   c_ext, r_ext, c_plus, r_plus;
   logic [conv3g_pkg::CNT_W-1:0]   width_ext, eff_w, eff_h;

   logic [2*conv3g_pkg::PIXEL_W-1:0] ram_rd_data;
   logic [conv3g_pkg::PIXEL_W-1:0]   top_px, mid_px;
   logic                             ram_wr_en;

   logic signed [conv3g_pkg::WEIGHT_W-1:0] weight_k;
   logic signed [conv3g_pkg::PROD_W-1:0]   pix_s, weight_s, product;
   logic signed [conv3g_pkg::ACC_W-1:0]    acc_adj, acc_half, half_val;
   logic [conv3g_pkg::PIXEL_W-1:0]         clamped;
   logic                                   out_free;

   conv3g_pkg::div_cmd_type div_cmd;
   conv3g_pkg::div_res_type div_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= conv3g_pkg::WIDTH_RESET;
         height_ff  <= conv3g_pkg::HEIGHT_RESET;
         weights_ff <= conv3g_pkg::WEIGHTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            conv3g_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[conv3g_pkg::WIDTH_REG_W-1:0];
            end
            conv3g_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data[conv3g_pkg::HEIGHT_REG_W-1:0];
            end
            conv3g_pkg::CSR_KERNEL_WEIGHTS: begin
               weights_ff <= csr_data[conv3g_pkg::WEIGHTS_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign width_ext = conv3g_pkg::CNT_W'(width_ff);
   assign eff_w = (width_ext < conv3g_pkg::MIN_DIM) ? conv3g_pkg::MIN_DIM :
                  (width_ext > MAX_W_EXT) ? MAX_W_EXT : width_ext;
   assign eff_h = (height_ff < conv3g_pkg::MIN_DIM) ? conv3g_pkg::MIN_DIM :
                  (height_ff > conv3g_pkg::HEIGHT_LIMIT) ? conv3g_pkg::HEIGHT_LIMIT : height_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;

   // Position of the arriving pixel and of the next one.
   assign c_sel  = req_ch.frame_start ? '0 : col_ff;
   assign r_sel  = req_ch.frame_start ? '0 : row_ff;
   assign c_ext  = conv3g_pkg::CNT_W'(c_sel);
   assign r_ext  = conv3g_pkg::CNT_W'(r_sel);
   assign c_plus = c_ext + 1'b1;
   assign r_plus = r_ext + 1'b1;

   always_comb begin
      if (c_plus >= eff_w) begin
         col_in = '0;
         row_in = (r_plus >= eff_h) ? '0 : r_plus[conv3g_pkg::ROW_W-1:0];
      end else begin
         col_in = c_plus[COL_W-1:0];
         row_in = (r_ext >= eff_h) ? '0 : r_sel;
      end
   end

   assign produce_in = (r_ext >= 13'd2) && (c_ext >= 13'd2) && (r_ext < eff_h) && (c_ext < eff_w);
   assign last_in    = (r_ext == eff_h - 1'b1) && (c_ext == eff_w - 1'b1);

   // Line store: upper byte two rows up, lower byte one row up.
   assign ram_wr_en = (state_ff == ST_READ);
   assign top_px    = ram_rd_data[2*conv3g_pkg::PIXEL_W-1:conv3g_pkg::PIXEL_W];
   assign mid_px    = ram_rd_data[conv3g_pkg::PIXEL_W-1:0];

   conv3g_ram #(
      .WIDTH (2 * conv3g_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({mid_px, px_ff}),
      .rd_en   (accept),
      .rd_addr (c_sel),
      .rd_data (ram_rd_data)
   );

   // One tap of the window per cycle through a single multiplier.
   assign weight_k = $signed(weights_ff[conv3g_pkg::WEIGHT_W*tap_ff +: conv3g_pkg::WEIGHT_W]);
   assign pix_s    = $signed({{(conv3g_pkg::PROD_W-conv3g_pkg::PIXEL_W){1'b0}},
                              window_ff[tap_ff]});
   assign weight_s = conv3g_pkg::PROD_W'(weight_k);
   assign product  = pix_s * weight_s;

   // Halving truncates toward zero, so a negative sum is bumped by one first.
   assign acc_adj  = acc_ff + $signed({{(conv3g_pkg::ACC_W-1){1'b0}}, acc_ff[conv3g_pkg::ACC_W-1]});
   assign acc_half = acc_adj >>> 1;
   assign half_val = acc_half + $signed(conv3g_pkg::ACC_W'(conv3g_pkg::HALF_OFFSET));

   assign clamped = (value_ff < 0) ? '0 :
                    (value_ff > $signed(conv3g_pkg::ACC_W'(conv3g_pkg::PIXEL_MAX))) ?
                       conv3g_pkg::PIXEL_W'(conv3g_pkg::PIXEL_MAX) :
                       value_ff[conv3g_pkg::PIXEL_W-1:0];

   assign div_cmd.start    = (state_ff == ST_NORM) && (factor_ff != '0);
   assign div_cmd.dividend = acc_ff;
   assign div_cmd.divisor  = factor_ff;

   conv3g_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in         = state_ff;
      tap_in           = tap_ff;
      acc_in           = acc_ff;
      factor_in        = factor_ff;
      value_in         = value_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ch.ready;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            tap_in    = '0;
            acc_in    = '0;
            factor_in = '0;
            state_in  = produce_ff ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            acc_in    = acc_ff + conv3g_pkg::ACC_W'(product);
            factor_in = factor_ff + conv3g_pkg::FACTOR_W'(weight_k);
            tap_in    = tap_ff + 1'b1;
            if (tap_ff == conv3g_pkg::TAP_W'(conv3g_pkg::TAPS - 1)) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (factor_ff == '0) begin
               value_in = half_val;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               value_in = div_res.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = clamped;
               rsp_frame_end_in = last_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < conv3g_pkg::TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (state_ff == ST_READ) begin
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[2] <= top_px;
            window_ff[3] <= window_ff[4];
            window_ff[4] <= window_ff[5];
            window_ff[5] <= mid_px;
            window_ff[6] <= window_ff[7];
            window_ff[7] <= window_ff[8];
            window_ff[8] <= px_ff;
         end
      end
      if (accept) begin
         addr_ff    <= c_sel;
         px_ff      <= req_ch.pixel;
         produce_ff <= produce_in;
         last_ff    <= last_in;
      end
      tap_ff           <= tap_in;
      acc_ff           <= acc_in;
      factor_ff        <= factor_in;
      value_ff         <= value_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.filtered  = rsp_filtered_ff;
   assign rsp_ch.frame_end = rsp_frame_end_ff;

endmodule

// ----- design/conv3g_checker.sv -----
module conv3g_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_filtered,
   input logic       rsp_frame_end
);

   // A waiting result holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered) && $stable(rsp_frame_end))
      else $error("result changed or dropped while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Each accepted item is followed by the line store write-back, during which input is held off.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken in the write-back cycle");

   // A new result is loaded only while input is held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result loaded while input was open");

endmodule

bind conv3x3_gray_normalized conv3g_checker u_conv3g_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_filtered  (rsp_ch.filtered),
   .rsp_frame_end (rsp_ch.frame_end)
);
